@@ src/audio_amplitude_envelope_assert.svh @@
// Assertion macros shared by the envelope RTL.
`ifndef AUDIO_AMPLITUDE_ENVELOPE_ASSERT_SVH
`define AUDIO_AMPLITUDE_ENVELOPE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define AAE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("envelope assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define AAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("envelope assertion failed");

`endif

@@ src/aae_pkg.sv @@
// Types, constants and the attack shape table for the amplitude envelope.
`timescale 1ns / 1ps

package aae_pkg;

  // Phase boundaries in sample positions.
  localparam logic [15:0] ATTACK_END  = 16'd6400;
  localparam logic [15:0] SUSTAIN_END = 16'd24880;
  localparam logic [15:0] RELEASE_END = 16'd31600;

  localparam logic [9:0]  ATTACK_MUL  = 10'd655;
  localparam logic [9:0]  RELEASE_MUL = 10'd624;
  localparam logic [10:0] UNITY       = 11'd1024;
  // 8 vibrato periods per envelope period times 2048 angle steps.
  localparam logic [16:0] VIB_STEP    = 17'd16384;
  localparam logic [11:0] SAMPLE_MAX  = 12'd4095;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 11;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Register file.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_PEAK  = 2'd0;
  localparam logic [1:0] REG_HOLD  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;

  localparam logic [9:0] PEAK_RST  = 10'd800;
  localparam logic [9:0] HOLD_RST  = 10'd850;
  localparam logic [6:0] DEPTH_RST = 7'd50;

  typedef struct packed {
    logic [9:0] peak_level;
    logic [9:0] hold_level;
    logic [6:0] vibrato_depth;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4
  } state_t;

  typedef enum logic [1:0] {
    PH_ATTACK,
    PH_SUSTAIN,
    PH_RELEASE,
    PH_OFF
  } phase_t;

  function automatic logic [10:0] shape_lut(input logic [5:0] idx);
    logic [10:0] v;
    case (idx)
      6'd0:  v = 11'd0;
      6'd1:  v = 11'd180;
      6'd2:  v = 11'd255;
      6'd3:  v = 11'd312;
      6'd4:  v = 11'd360;
      6'd5:  v = 11'd403;
      6'd6:  v = 11'd442;
      6'd7:  v = 11'd478;
      6'd8:  v = 11'd512;
      6'd9:  v = 11'd544;
      6'd10: v = 11'd574;
      6'd11: v = 11'd603;
      6'd12: v = 11'd630;
      6'd13: v = 11'd656;
      6'd14: v = 11'd681;
      6'd15: v = 11'd705;
      6'd16: v = 11'd728;
      6'd17: v = 11'd750;
      6'd18: v = 11'd771;
      6'd19: v = 11'd792;
      6'd20: v = 11'd812;
      6'd21: v = 11'd831;
      6'd22: v = 11'd850;
      6'd23: v = 11'd868;
      6'd24: v = 11'd885;
      6'd25: v = 11'd902;
      6'd26: v = 11'd918;
      6'd27: v = 11'd933;
      6'd28: v = 11'd949;
      6'd29: v = 11'd963;
      6'd30: v = 11'd977;
      6'd31: v = 11'd991;
      6'd32: v = 11'd1024;
      default: v = 11'd1024;
    endcase
    return v;
  endfunction

endpackage

@@ src/audio_amplitude_envelope.sv @@
// Top level: attack-sustain-release amplitude envelope on a sample stream.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------
//  input     | in_valid / in_ready     | sample_in[11:0]
//  output    | out_valid / out_ready   | sample_out[11:0]
//  config    | psel penable pwrite     | paddr[3:0] pwdata prdata
//
// For each beat one shared multiplier runs four products in a
// row (phase term, shape/vibrato/release term, level scaling, sample scaling).
// The output register takes the result while the next beat is accepted.
// in_ready drops while the sequencer runs, or while a finished result waits
// behind a full output register that is not being drained.
// rst is synchronous: position, vibrato tracker and registers return to
// their initial values; no clearing pass.
`timescale 1ns / 1ps

module audio_amplitude_envelope #(
  parameter int SAMPLES_PER_CYCLE = 32000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [11:0]                sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [11:0]                sample_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aae_pkg::ADDR_W-1:0] paddr,
  input  logic [aae_pkg::DATA_W-1:0] pwdata,
  output logic [aae_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam logic [15:0] SPC_LAST = 16'(SAMPLES_PER_CYCLE - 1);

  aae_pkg::cfg_t   cfg;
  aae_pkg::state_t state;
  aae_pkg::state_t state_next;
  aae_pkg::phase_t phase;

  logic [15:0] pos;
  logic [11:0] sample;
  logic [9:0]  base;
  logic        pend;

  logic                        mul_en;
  logic [aae_pkg::MUL_A_W-1:0] mul_a;
  logic [aae_pkg::MUL_B_W-1:0] mul_b;
  logic [aae_pkg::MUL_P_W-1:0] p;

  logic [10:0] ang;
  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        done;

  // combinational helpers
  logic [15:0] rel_pos;
  logic [4:0]  idx;
  logic [10:0] lo;
  logic [10:0] hi;
  logic [10:0] norm;
  logic [10:0] inv;
  logic [10:0] lin;
  logic [8:0]  vib_dn;
  logic [10:0] fac_s;
  logic [10:0] fac;

  assign pready = 1'b1;

  aae_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  aae_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  aae_vib #(
    .SAMPLES_PER_CYCLE (SAMPLES_PER_CYCLE)
  ) u_vib (
    .clk   (clk),
    .rst   (rst),
    .step  (done && (phase == aae_pkg::PH_SUSTAIN)),
    .clear (done && (phase != aae_pkg::PH_SUSTAIN)),
    .ang   (ang)
  );

  always_comb begin
    if (pos < aae_pkg::ATTACK_END) begin
      phase = aae_pkg::PH_ATTACK;
    end else if (pos < aae_pkg::SUSTAIN_END) begin
      phase = aae_pkg::PH_SUSTAIN;
    end else if (pos < aae_pkg::RELEASE_END) begin
      phase = aae_pkg::PH_RELEASE;
    end else begin
      phase = aae_pkg::PH_OFF;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == aae_pkg::ST_IDLE) && (!pend || out_free);
  assign accept   = in_valid && in_ready;
  assign out_load = pend && out_free;
  assign done     = (state == aae_pkg::ST_MUL4);

  // datapath terms taken from the running product
  always_comb begin
    rel_pos = pos - aae_pkg::SUSTAIN_END;
    idx     = p[21:17];
    lo      = aae_pkg::shape_lut({1'b0, idx});
    hi      = aae_pkg::shape_lut({1'b0, idx} + 6'd1);
    norm    = p[22:12];
    if (norm > aae_pkg::UNITY) begin
      norm = aae_pkg::UNITY;
    end
    inv     = aae_pkg::UNITY - norm;
    lin     = {1'b0, base} + p[15:5];
    // negative vibrato rounds toward minus infinity
    vib_dn  = 9'((p[16:0] + 17'd255) >> 8);
    if (!ang[10]) begin
      fac_s = {1'b0, cfg.hold_level} + {2'b00, p[16:8]};
    end else if ({1'b0, cfg.hold_level} >= {2'b00, vib_dn}) begin
      fac_s = {1'b0, cfg.hold_level} - {2'b00, vib_dn};
    end else begin
      fac_s = '0;
    end
    case (phase)
      aae_pkg::PH_ATTACK,
      aae_pkg::PH_SUSTAIN: fac = p[20:10];
      aae_pkg::PH_RELEASE: fac = p[30:20];
      default:             fac = '0;
    endcase
  end

  // sequencer and operand select
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      aae_pkg::ST_IDLE: begin
        mul_en = accept;
        case (phase)
          aae_pkg::PH_ATTACK: begin
            mul_a = aae_pkg::MUL_A_W'(pos[12:0]);
            mul_b = {1'b0, aae_pkg::ATTACK_MUL};
          end
          aae_pkg::PH_SUSTAIN: begin
            mul_a = aae_pkg::MUL_A_W'(ang[9:0]);
            mul_b = aae_pkg::UNITY - {1'b0, ang[9:0]};
          end
          aae_pkg::PH_RELEASE: begin
            mul_a = aae_pkg::MUL_A_W'(rel_pos[12:0]);
            mul_b = {1'b0, aae_pkg::RELEASE_MUL};
          end
          default: ;
        endcase
        if (accept) begin
          state_next = aae_pkg::ST_MUL2;
        end
      end
      aae_pkg::ST_MUL2: begin
        mul_en = 1'b1;
        case (phase)
          aae_pkg::PH_ATTACK: begin
            mul_a = aae_pkg::MUL_A_W'(hi - lo);
            mul_b = aae_pkg::MUL_B_W'(p[16:12]);
          end
          aae_pkg::PH_SUSTAIN: begin
            mul_a = aae_pkg::MUL_A_W'(p[18:9]);
            mul_b = aae_pkg::MUL_B_W'(cfg.vibrato_depth);
          end
          aae_pkg::PH_RELEASE: begin
            mul_a = aae_pkg::MUL_A_W'(inv);
            mul_b = inv;
          end
          default: ;
        endcase
        state_next = aae_pkg::ST_MUL3;
      end
      aae_pkg::ST_MUL3: begin
        mul_en = 1'b1;
        case (phase)
          aae_pkg::PH_ATTACK: begin
            mul_a = aae_pkg::MUL_A_W'(lin);
            mul_b = {1'b0, cfg.peak_level};
          end
          aae_pkg::PH_SUSTAIN: begin
            mul_a = aae_pkg::MUL_A_W'(fac_s);
            mul_b = aae_pkg::UNITY;
          end
          aae_pkg::PH_RELEASE: begin
            mul_a = p[20:0];
            mul_b = {1'b0, cfg.hold_level};
          end
          default: ;
        endcase
        state_next = aae_pkg::ST_MUL4;
      end
      aae_pkg::ST_MUL4: begin
        mul_en     = 1'b1;
        mul_a      = aae_pkg::MUL_A_W'(sample);
        mul_b      = fac;
        state_next = aae_pkg::ST_IDLE;
      end
      default: begin
        state_next = aae_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aae_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        pos <= (pos >= SPC_LAST) ? 16'd0 : pos + 16'd1;
      end
      if (done) begin
        pend <= 1'b1;
      end else if (out_load) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= sample_in;
    end
    if (state == aae_pkg::ST_MUL2) begin
      base <= lo[9:0];
    end
    if (out_load) begin
      sample_out <= (|p[aae_pkg::MUL_P_W-1:22]) ? aae_pkg::SAMPLE_MAX : p[21:10];
    end
  end

  `include "audio_amplitude_envelope_assert.svh"

  `AAE_ASSERT_NEXT(a_accept_starts, accept, state == aae_pkg::ST_MUL2)
  `AAE_ASSERT_NOW(a_out_from_pending, $rose(out_valid), $past(pend))
  `AAE_ASSERT_NEXT(a_pos_holds, !done, $stable(pos))
  `AAE_ASSERT_NOW(a_pos_range, 1'b1, pos <= SPC_LAST)
  `AAE_ASSERT_NOW(a_no_accept_busy, state != aae_pkg::ST_IDLE, !in_ready)

endmodule

@@ src/aae_mul.sv @@
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps

module aae_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [aae_pkg::MUL_A_W-1:0] a,
  input  logic [aae_pkg::MUL_B_W-1:0] b,
  output logic [aae_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= aae_pkg::MUL_P_W'(a) * aae_pkg::MUL_P_W'(b);
    end
  end

endmodule

@@ src/aae_vib.sv @@
// Vibrato angle tracker: steps the angle one sustain sample at a time.
`timescale 1ns / 1ps

module aae_vib #(
  parameter int SAMPLES_PER_CYCLE = 32000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        clear,
  output logic [10:0] ang
);

  localparam logic [16:0] SPC = 17'(SAMPLES_PER_CYCLE);

  // ang*SPC + rem tracks (8*spos mod SPC)*2048; ang wraps mod 2048 with it.
  logic [15:0] rem;
  logic [15:0] rem_next;
  logic [10:0] ang_next;
  logic [16:0] sum;

  always_comb begin
    sum      = {1'b0, rem} + aae_pkg::VIB_STEP;
    rem_next = rem;
    ang_next = ang;
    if (clear) begin
      rem_next = '0;
      ang_next = '0;
    end else if (step) begin
      if (sum >= SPC) begin
        rem_next = 16'(sum - SPC);
        ang_next = ang + 11'd1;
      end else begin
        rem_next = sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      ang <= '0;
    end else begin
      rem <= rem_next;
      ang <= ang_next;
    end
  end

endmodule

@@ src/aae_regs.sv @@
// APB-style configuration registers for the envelope.
`timescale 1ns / 1ps

module aae_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aae_pkg::ADDR_W-1:0] paddr,
  input  logic [aae_pkg::DATA_W-1:0] pwdata,
  output logic [aae_pkg::DATA_W-1:0] prdata,
  output aae_pkg::cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_level    <= aae_pkg::PEAK_RST;
      cfg.hold_level    <= aae_pkg::HOLD_RST;
      cfg.vibrato_depth <= aae_pkg::DEPTH_RST;
    end else if (wr) begin
      case (idx)
        aae_pkg::REG_PEAK:  cfg.peak_level    <= pwdata[9:0];
        aae_pkg::REG_HOLD:  cfg.hold_level    <= pwdata[9:0];
        aae_pkg::REG_DEPTH: cfg.vibrato_depth <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aae_pkg::REG_PEAK:  prdata = {22'd0, cfg.peak_level};
      aae_pkg::REG_HOLD:  prdata = {22'd0, cfg.hold_level};
      aae_pkg::REG_DEPTH: prdata = {25'd0, cfg.vibrato_depth};
      default:            prdata = '0;
    endcase
  end

endmodule
